@@ src/mups_pkg.sv @@
// ----------------------------------------------------------------------------
// mups_pkg: shared definitions for the masked unique pattern scan
// Constants, register indexes and the structs that pass between the cells,
// the tally unit and the top level.
// ----------------------------------------------------------------------------
package mups_pkg;

  // Longest pattern that the cell row can hold.
  localparam int MAX_PATTERN_BYTES = 32;
  localparam int IDX_W             = $clog2(MAX_PATTERN_BYTES);
  localparam int LEN_W             = 6;
  localparam int PAT_BITS          = 8 * MAX_PATTERN_BYTES;
  localparam int OFFSET_W          = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_BITS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd5;

  // Pattern settings as seen by every cell; len is already clamped to 1..MAX.
  typedef struct packed {
    logic [PAT_BITS-1:0]          pattern;
    logic [MAX_PATTERN_BYTES-1:0] care;
    logic [LEN_W-1:0]             len;
  } cfg_t;

  // One scanned byte on its way from the cell row to the tally unit.
  typedef struct packed {
    logic                hit;
    logic                last;
    logic [OFFSET_W-1:0] offset;
  } scan_item_t;

endpackage

@@ src/mups_cell.sv @@
// ----------------------------------------------------------------------------
// mups_cell: one window position of the scan row
// Holds one byte of the sliding window with its valid bit, takes its
// neighbor's byte on every accepted transaction, and checks the incoming byte
// against the pattern byte that lines up with this position.
// ----------------------------------------------------------------------------
module mups_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mups_pkg::IDX_W-1:0]      cell_idx,
  input  logic                            shift_en,
  input  logic                            clear,
  input  mups_pkg::cfg_t                  cfg,
  input  logic [7:0]                      prev_byte,
  input  logic                            prev_vld,
  output logic [7:0]                      byte_q,
  output logic                            vld_q,
  output logic                            ok
);

  logic [7:0]                   byte_r;
  logic                         vld_r;
  logic                         vld_nxt;
  logic [mups_pkg::LEN_W-1:0]   idx_ext;
  logic [mups_pkg::LEN_W-1:0]   pat_pos;
  logic [mups_pkg::IDX_W-1:0]   sel;
  logic                         in_use;
  logic [7:0]                   want;
  logic                         care;

  // Pattern byte len-1-idx lines up with this position (newest byte at 0).
  assign idx_ext = {{(mups_pkg::LEN_W - mups_pkg::IDX_W){1'b0}}, cell_idx};
  assign pat_pos = cfg.len - mups_pkg::LEN_W'(1) - idx_ext;
  assign sel     = pat_pos[mups_pkg::IDX_W-1:0];
  assign in_use  = idx_ext < cfg.len;
  assign want    = cfg.pattern[{sel, 3'b000} +: 8];
  assign care    = cfg.care[sel];

  // The check runs on the byte that is about to enter this position.
  assign ok = !in_use || (prev_vld && (!care || (prev_byte == want)));

  // Valid bits shift with the data and drop at the end of a range.
  always_comb begin
    vld_nxt = vld_r;
    if (shift_en) begin
      vld_nxt = clear ? 1'b0 : prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= prev_byte;
    end
  end

  assign byte_q = byte_r;
  assign vld_q  = vld_r;

endmodule

@@ src/mups_tally.sv @@
// ----------------------------------------------------------------------------
// mups_tally: match tally and result register
// Counts window matches with saturation at two, keeps the offset of the first
// match, and loads the result register on the byte that closes a range.
// ----------------------------------------------------------------------------
module mups_tally (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  input  mups_pkg::scan_item_t              item,
  output logic                              item_take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_unique,
  output logic                              out_several,
  output logic [mups_pkg::OFFSET_W-1:0]     out_offset
);

  logic [1:0]                      tally_r;
  logic [1:0]                      tally_nxt;
  logic [1:0]                      tally_upd;
  logic [mups_pkg::OFFSET_W-1:0]   first_r;
  logic [mups_pkg::OFFSET_W-1:0]   first_nxt;
  logic [mups_pkg::OFFSET_W-1:0]   first_upd;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic                            out_unique_r;
  logic                            out_several_r;
  logic [mups_pkg::OFFSET_W-1:0]   out_offset_r;
  logic                            out_free;
  logic                            closing;

  // A closing byte waits only while the result register is still occupied.
  assign out_free  = !out_valid_r || out_ready;
  assign item_take = item_valid && (!item.last || out_free);
  assign closing   = item_take && item.last;

  // Saturating tally and first-match offset after this byte.
  always_comb begin
    tally_upd = tally_r;
    first_upd = first_r;
    if (item.hit) begin
      if (tally_r == 2'd0) begin
        first_upd = item.offset;
      end
      if (tally_r != 2'd2) begin
        tally_upd = tally_r + 2'd1;
      end
    end
  end

  always_comb begin
    tally_nxt = tally_r;
    first_nxt = first_r;
    if (item_take) begin
      tally_nxt = item.last ? 2'd0 : tally_upd;
      first_nxt = item.last ? '0 : first_upd;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (closing) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r     <= 2'd0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tally_r     <= tally_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (closing) begin
      out_unique_r  <= (tally_upd == 2'd1);
      out_several_r <= (tally_upd == 2'd2);
      out_offset_r  <= (tally_upd != 2'd0) ? first_upd : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_unique  = out_unique_r;
  assign out_several = out_several_r;
  assign out_offset  = out_offset_r;

endmodule

@@ src/masked_unique_pattern_scan_core.sv @@
// ----------------------------------------------------------------------------
// masked_unique_pattern_scan_core: masked byte pattern scan, unique match
// The byte marked last is registered in stage A at the edge that takes it, and its
// result loads the output register once the tally unit takes it from stage A.
// Throughput: one byte per cycle; a row of 32 cells checks every window
// position in the cycle a byte enters, and the tally unit updates once a byte.
// Only a result still waiting at the output holds off the next closing byte.
// Reset (rst_n low at a clock edge) clears the scan state, the pattern
// registers and care bits, and sets the pattern length to one.
// ----------------------------------------------------------------------------
module masked_unique_pattern_scan_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // is_last
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mups_pkg::OFFSET_W-1:0]       out_tdata,  // [31:0] match_offset
  output logic [1:0]                          out_tuser,  // [0] unique_found,
                                                          // [1] several_found
  // Configuration port.
  input  logic                                cfg_we,
  input  logic [mups_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mups_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int N = mups_pkg::MAX_PATTERN_BYTES;

  logic [mups_pkg::PAT_BITS-1:0]   pattern_r;
  logic [N-1:0]                    care_r;
  logic [mups_pkg::LEN_W-1:0]      len_r;
  logic [mups_pkg::LEN_W-1:0]      len_eff;
  mups_pkg::cfg_t                  cfg;

  logic                            accept;
  logic [7:0]                      win_byte [N];
  logic [N-1:0]                    win_vld;
  logic [N-1:0]                    cell_ok;

  logic [mups_pkg::OFFSET_W-1:0]   seen_r;
  logic [mups_pkg::OFFSET_W-1:0]   seen_nxt;
  logic [mups_pkg::OFFSET_W-1:0]   seen_inc;

  logic                            a_valid_r;
  logic                            a_valid_nxt;
  mups_pkg::scan_item_t            a_item_r;
  mups_pkg::scan_item_t            a_item_nxt;
  logic                            a_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      care_r    <= '0;
      len_r     <= mups_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mups_pkg::REG_PATTERN_WORD0: pattern_r[0*64 +: 64] <= cfg_wdata;
        mups_pkg::REG_PATTERN_WORD1: pattern_r[1*64 +: 64] <= cfg_wdata;
        mups_pkg::REG_PATTERN_WORD2: pattern_r[2*64 +: 64] <= cfg_wdata;
        mups_pkg::REG_PATTERN_WORD3: pattern_r[3*64 +: 64] <= cfg_wdata;
        mups_pkg::REG_CARE_BITS:     care_r <= cfg_wdata[N-1:0];
        mups_pkg::REG_PATTERN_LEN:   len_r  <= cfg_wdata[mups_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to 1..N.
  always_comb begin
    len_eff = len_r;
    if (len_r == '0) begin
      len_eff = mups_pkg::LEN_W'(1);
    end else if (len_r > mups_pkg::LEN_W'(N)) begin
      len_eff = mups_pkg::LEN_W'(N);
    end
  end

  assign cfg.pattern = pattern_r;
  assign cfg.care    = care_r;
  assign cfg.len     = len_eff;

  // Input handshake: stage A frees whenever the tally unit takes its item.
  assign in_tready = !a_valid_r || a_take;
  assign accept    = in_tvalid && in_tready;

  // Row of window cells; cell 0 takes the incoming byte.
  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [7:0] prev_byte;
    logic       prev_vld;
    if (k == 0) begin : g_head
      assign prev_byte = in_tdata;
      assign prev_vld  = 1'b1;
    end else begin : g_body
      assign prev_byte = win_byte[k-1];
      assign prev_vld  = win_vld[k-1];
    end
    mups_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (mups_pkg::IDX_W'(k)),
      .shift_en  (accept),
      .clear     (in_tlast),
      .cfg       (cfg),
      .prev_byte (prev_byte),
      .prev_vld  (prev_vld),
      .byte_q    (win_byte[k]),
      .vld_q     (win_vld[k]),
      .ok        (cell_ok[k])
    );
  end

  // Saturating byte counter of the current range.
  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + mups_pkg::OFFSET_W'(1);

  always_comb begin
    seen_nxt = seen_r;
    if (accept) begin
      seen_nxt = in_tlast ? '0 : seen_inc;
    end
  end

  // Stage A: match flag and candidate offset for the byte just taken.
  always_comb begin
    a_item_nxt.hit    = &cell_ok;
    a_item_nxt.last   = in_tlast;
    a_item_nxt.offset = seen_inc - {{(mups_pkg::OFFSET_W - mups_pkg::LEN_W){1'b0}}, len_eff};
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (a_take) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      a_valid_r <= 1'b0;
    end else begin
      seen_r    <= seen_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r <= a_item_nxt;
    end
  end

  // Tally and result register.
  mups_tally u_tally (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (a_valid_r),
    .item        (a_item_r),
    .item_take   (a_take),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_unique  (out_tuser[0]),
    .out_several (out_tuser[1]),
    .out_offset  (out_tdata)
  );

endmodule
